>>> hdl/slhm_pkg.sv
// shared types and constants for the serial link health monitor
`timescale 1ns / 1ps

package slhm_pkg;

    // silence and restart timer width
    localparam int TIMER_WIDTH = 17;
    // width used to compare a timer against a 16-bit threshold
    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [15:0] SIGNAL_LOST_RST = 16'd100;
    localparam logic [15:0] POWER_LOST_RST  = 16'd500;
    localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd3;
    localparam logic [15:0] AUTO_RESET_RST  = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGNAL_LOST = 2'd0,
        CFG_POWER_LOST  = 2'd1,
        CFG_FAIL_LIMIT  = 2'd2,
        CFG_AUTO_RESET  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_TICK         = 2'd0,
        MODE_FRAME        = 2'd1,
        MODE_MANUAL_RESET = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        LINK_NORMAL       = 2'd0,
        LINK_SIGNAL_LOST  = 2'd1,
        LINK_POWER_LOST   = 2'd2,
        LINK_RECONNECTING = 2'd3
    } t_link;

    typedef struct packed {
        logic [15:0] sig_lost_thr;
        logic [15:0] pwr_lost_thr;
        logic [7:0]  fail_limit;
        logic [15:0] auto_reset_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic       crc_good;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

endpackage

>>> hdl/slhm_if.sv
// channel interfaces: input items, result items and register writes
`timescale 1ns / 1ps

interface slhm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       crc_good;

    modport source (output valid, output mode, output crc_good, input ready);
    modport sink   (input valid, input mode, input crc_good, output ready);
endinterface

interface slhm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] link_state;
    logic       data_valid;
    logic       power_lost;
    logic       restart_request;
    logic [7:0] fail_count;

    modport source (output valid, output link_state, output data_valid, output power_lost,
                    output restart_request, output fail_count, input ready);
    modport sink   (input valid, input link_state, input data_valid, input power_lost,
                    input restart_request, input fail_count, output ready);
endinterface

interface slhm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/slhm_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module slhm_cfg_regs import slhm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slhm_cfg_if.sink     i_cfg,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sig_lost_thr  <= SIGNAL_LOST_RST;
            r_cfg.pwr_lost_thr  <= POWER_LOST_RST;
            r_cfg.fail_limit    <= FAIL_LIMIT_RST;
            r_cfg.auto_reset_ms <= AUTO_RESET_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SIGNAL_LOST: r_cfg.sig_lost_thr  <= i_cfg.data;
                CFG_POWER_LOST:  r_cfg.pwr_lost_thr  <= i_cfg.data;
                CFG_FAIL_LIMIT:  r_cfg.fail_limit    <= i_cfg.data[7:0];
                CFG_AUTO_RESET:  r_cfg.auto_reset_ms <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/slhm_in_stage.sv
// input register stage
`timescale 1ns / 1ps

module slhm_in_stage import slhm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slhm_in_if.sink    i_in,
    input  logic       i_advance,
    output t_stage     o_stage
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // take a new transaction when empty or when the held one moves on
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.mode     <= i_in.mode;
            r_item.crc_good <= i_in.crc_good;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

>>> hdl/slhm_health_core.sv
// link state, timers, failure run and result register
`timescale 1ns / 1ps

module slhm_health_core import slhm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_stage      i_stage,
    slhm_out_if.source  o_out,
    output logic        o_advance
);

    t_link                  r_link, n_link;
    logic [TIMER_WIDTH-1:0] r_silence, n_silence;
    logic [TIMER_WIDTH-1:0] r_since, n_since;
    logic [7:0]             r_fail_run, n_fail_run;
    logic                   r_last_good, n_last_good;
    logic                   r_valid_flag, n_valid_flag;
    logic                   n_restart;

    logic                   r_out_valid;
    t_link                  r_out_link;
    logic                   r_out_data_valid;
    logic                   r_out_restart;
    logic [7:0]             r_out_fail;

    logic [TIMER_WIDTH-1:0] silence_inc, since_inc;
    logic                   power_hit, signal_hit, auto_hit;
    logic                   fire;

    assign o_advance = !r_out_valid || o_out.ready;
    assign fire      = i_stage.valid && o_advance;

    // saturating timer increments and timeout compares
    always_comb begin
        silence_inc = (r_silence == TIMER_MAX) ? r_silence : r_silence + TIMER_WIDTH'(1);
        since_inc   = (r_since == TIMER_MAX) ? r_since : r_since + TIMER_WIDTH'(1);
        power_hit   = CMP_W'(silence_inc) > CMP_W'(i_cfg.pwr_lost_thr);
        signal_hit  = CMP_W'(silence_inc) > CMP_W'(i_cfg.sig_lost_thr);
        auto_hit    = CMP_W'(since_inc) > CMP_W'(i_cfg.auto_reset_ms);
    end

    // link state next value
    always_comb begin
        n_link = r_link;
        case (t_mode'(i_stage.item.mode))
            MODE_TICK: begin
                unique case (r_link)
                    LINK_NORMAL: begin
                        if (power_hit) begin
                            n_link = LINK_POWER_LOST;
                        end else if (signal_hit) begin
                            n_link = LINK_SIGNAL_LOST;
                        end
                    end
                    LINK_POWER_LOST: begin
                        if (auto_hit) begin
                            n_link = LINK_RECONNECTING;
                        end
                    end
                    default: begin
                        if (power_hit) begin
                            n_link = LINK_POWER_LOST;
                        end
                    end
                endcase
            end
            MODE_FRAME: begin
                if (i_stage.item.crc_good) begin
                    n_link = LINK_NORMAL;
                end
            end
            MODE_MANUAL_RESET: n_link = LINK_RECONNECTING;
            default: ;
        endcase
    end

    // timers, failure run, restart pulse
    always_comb begin
        n_silence   = r_silence;
        n_since     = r_since;
        n_fail_run  = r_fail_run;
        n_last_good = r_last_good;
        n_restart   = 1'b0;
        case (t_mode'(i_stage.item.mode))
            MODE_TICK: begin
                n_silence = silence_inc;
                n_since   = since_inc;
                if (r_link == LINK_POWER_LOST && auto_hit) begin
                    n_fail_run = '0;
                    n_silence  = '0;
                    n_since    = '0;
                    n_restart  = 1'b1;
                end
            end
            MODE_FRAME: begin
                if (i_stage.item.crc_good) begin
                    n_fail_run  = '0;
                    n_last_good = 1'b1;
                    n_silence   = '0;
                end else begin
                    n_last_good = 1'b0;
                    if (r_fail_run < i_cfg.fail_limit) begin
                        n_fail_run = r_fail_run + 8'd1;
                    end
                end
            end
            MODE_MANUAL_RESET: begin
                n_fail_run = '0;
                n_silence  = '0;
                n_restart  = 1'b1;
            end
            default: ;
        endcase
    end

    // data valid flag
    always_comb begin
        n_valid_flag = r_valid_flag;
        if (n_link != LINK_NORMAL || n_fail_run >= i_cfg.fail_limit) begin
            n_valid_flag = 1'b0;
        end else if (n_last_good) begin
            n_valid_flag = 1'b1;
        end
    end

    // state update, one transaction per cycle while the result side can advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link       <= LINK_RECONNECTING;
            r_silence    <= '0;
            r_since      <= '0;
            r_fail_run   <= '0;
            r_last_good  <= 1'b0;
            r_valid_flag <= 1'b0;
        end else if (fire) begin
            r_link       <= n_link;
            r_silence    <= n_silence;
            r_since      <= n_since;
            r_fail_run   <= n_fail_run;
            r_last_good  <= n_last_good;
            r_valid_flag <= n_valid_flag;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_stage.valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_link       <= n_link;
            r_out_data_valid <= n_valid_flag;
            r_out_restart    <= n_restart;
            r_out_fail       <= n_fail_run;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.link_state      = r_out_link;
    assign o_out.data_valid      = r_out_data_valid;
    assign o_out.power_lost      = (r_out_link == LINK_POWER_LOST);
    assign o_out.restart_request = r_out_restart;
    assign o_out.fail_count      = r_out_fail;

endmodule

>>> hdl/serial_link_health_monitor_top.sv
// Serial link health monitor. Each transaction on i_in is a 1 ms tick, a checked frame with
// its CRC result, or a manual receiver reset, and yields exactly one result on o_out: link
// state, data valid, power lost, a one-transaction restart request and the CRC failure run.
// One transaction is accepted every clock cycle while i_in.ready is high. An accepted
// transaction sits in the input register, moves into the result register once that is free
// or being taken, and is shown on o_out from then on. A stalled result does not block the
// next accept while the input register is free; with both registers full, i_in.ready drops
// until o_out is taken. Registers on i_cfg must be written only while idle; the block
// itself does not enforce this.
`timescale 1ns / 1ps

module serial_link_health_monitor_top import slhm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slhm_in_if.sink     i_in,
    slhm_cfg_if.sink    i_cfg,
    slhm_out_if.source  o_out
);

    t_cfg   cfg;
    t_stage stage;
    logic   advance;

    // configuration registers
    slhm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // input register
    slhm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    // health logic and result register
    slhm_health_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_stage   (stage),
        .o_out     (o_out),
        .o_advance (advance)
    );

`ifndef SYNTHESIS
    // a restart always leaves the link reconnecting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.restart_request |-> o_out.link_state == LINK_RECONNECTING)
        else $error("restart without reconnecting state");

    // usable data only on a normal link below the failure limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data_valid |->
            o_out.link_state == LINK_NORMAL && o_out.fail_count < cfg.fail_limit)
        else $error("data valid on bad link");

    // a held transaction is not lost while the result side stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage.valid && !advance |=> stage.valid)
        else $error("input stage dropped a transaction");
`endif

endmodule

>>> sim/serial_link_health_monitor_top_tb.sv
// self-checking testbench for the serial link health monitor top level
`timescale 1ns / 1ps

module serial_link_health_monitor_top_tb;
    import slhm_pkg::*;

    // mode code the block leaves unused
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // result register depth plus margin
    localparam int SETTLE_CYCLES = 4;
    // cycles without any transaction before the run is aborted
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        t_link      link_state;
        logic       data_valid;
        logic       power_lost;
        logic       restart_request;
        logic [7:0] fail_count;
    } t_status;

    logic i_clk;
    logic i_rst_n;

    slhm_in_if  in_ch ();
    slhm_out_if out_ch ();
    slhm_cfg_if cfg_ch ();

    serial_link_health_monitor_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // predicted link supervisor state
    t_cfg                   link_cfg;
    t_link                  link_code;
    logic [TIMER_WIDTH-1:0] silence_ms;
    logic [TIMER_WIDTH-1:0] since_restart_ms;
    logic [7:0]             fail_run;
    logic                   last_good;
    logic                   valid_flag;

    t_status status_q[$];
    int      error_count;
    int      gap_level;
    int      stall_level;
    int      stall_left;
    int      quiet_cycles;
    t_status got_status;
    t_status want_status;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [TIMER_WIDTH-1:0] timer_step(input logic [TIMER_WIDTH-1:0] t);
        return (t == TIMER_MAX) ? t : t + TIMER_WIDTH'(1);
    endfunction

    // advance the predicted state by one transaction and return the status it yields
    function automatic t_status next_status(input logic [1:0] mode, input logic good);
        logic    restart;
        t_status s;
        restart = 1'b0;
        case (mode)
            MODE_TICK: begin
                silence_ms       = timer_step(silence_ms);
                since_restart_ms = timer_step(since_restart_ms);
                case (link_code)
                    LINK_NORMAL: begin
                        if (silence_ms > link_cfg.pwr_lost_thr)
                            link_code = LINK_POWER_LOST;
                        else if (silence_ms > link_cfg.sig_lost_thr)
                            link_code = LINK_SIGNAL_LOST;
                    end
                    LINK_POWER_LOST: begin
                        if (since_restart_ms > link_cfg.auto_reset_ms) begin
                            fail_run         = '0;
                            link_code        = LINK_RECONNECTING;
                            silence_ms       = '0;
                            since_restart_ms = '0;
                            restart          = 1'b1;
                        end
                    end
                    default: begin
                        if (silence_ms > link_cfg.pwr_lost_thr)
                            link_code = LINK_POWER_LOST;
                    end
                endcase
            end
            MODE_FRAME: begin
                if (good) begin
                    fail_run   = '0;
                    last_good  = 1'b1;
                    link_code  = LINK_NORMAL;
                    silence_ms = '0;
                end else begin
                    last_good = 1'b0;
                    if (fail_run < link_cfg.fail_limit)
                        fail_run = fail_run + 8'd1;
                end
            end
            MODE_MANUAL_RESET: begin
                fail_run   = '0;
                silence_ms = '0;
                link_code  = LINK_RECONNECTING;
                restart    = 1'b1;
            end
            default: ;
        endcase

        if (link_code != LINK_NORMAL || fail_run >= link_cfg.fail_limit)
            valid_flag = 1'b0;
        else if (last_good)
            valid_flag = 1'b1;

        s.link_state      = link_code;
        s.data_valid      = valid_flag;
        s.power_lost      = (link_code == LINK_POWER_LOST);
        s.restart_request = restart;
        s.fail_count      = fail_run;
        return s;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input int level);
        int r;
        r = $urandom_range(0, 99);
        if (level == 0)
            return 0;
        if (level == 1) begin
            if (r < 80) return 0;
            if (r < 97) return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(input string msg);
        error_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // send one transaction and record its expected status
    task automatic send_event(input logic [1:0] mode, input logic good);
        int gap;
        gap = pick_gap(gap_level);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid    = 1'b0;
            in_ch.mode     = 2'($urandom);
            in_ch.crc_good = 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid    = 1'b1;
        in_ch.mode     = mode;
        in_ch.crc_good = good;
        do @(posedge i_clk); while (!in_ch.ready);
        status_q.push_back(next_status(mode, good));
    endtask

    // register write, applied to the predictor when accepted
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_SIGNAL_LOST: link_cfg.sig_lost_thr  = data;
            CFG_POWER_LOST:  link_cfg.pwr_lost_thr  = data;
            CFG_FAIL_LIMIT:  link_cfg.fail_limit    = data[7:0];
            CFG_AUTO_RESET:  link_cfg.auto_reset_ms = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all(input logic [15:0] sig, input logic [15:0] pwr,
                             input logic [15:0] lim, input logic [15:0] aut);
        write_reg(CFG_SIGNAL_LOST, sig);
        write_reg(CFG_POWER_LOST, pwr);
        write_reg(CFG_FAIL_LIMIT, lim);
        write_reg(CFG_AUTO_RESET, aut);
    endtask

    // stop sending, wait for every status, then let the pipeline settle
    task automatic drain_and_settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // reset values: failure run saturation, recovery, unused mode, manual reset
    task automatic test_defaults();
        send_event(MODE_TICK, 1'b1);
        repeat (4) send_event(MODE_FRAME, 1'b0);
        send_event(MODE_FRAME, 1'b1);
        send_event(MODE_TICK, 1'b0);
        send_event(MODE_UNUSED, 1'b1);
        send_event(MODE_UNUSED, 1'b0);
        send_event(MODE_MANUAL_RESET, 1'b1);
        send_event(MODE_FRAME, 1'b1);
        send_event(MODE_TICK, 1'b0);
    endtask

    // small thresholds, junk in the upper bits of the limit, zero fail limit
    task automatic test_threshold_extremes();
        drain_and_settle();
        write_all(16'd1, 16'd2, 16'hFF01, 16'd1);
        send_event(MODE_FRAME, 1'b1);
        repeat (5) send_event(MODE_TICK, 1'b1);
        send_event(MODE_FRAME, 1'b0);
        send_event(MODE_FRAME, 1'b1);
        drain_and_settle();
        write_reg(CFG_FAIL_LIMIT, 16'h0000);
        send_event(MODE_FRAME, 1'b1);
        send_event(MODE_FRAME, 1'b0);
        send_event(MODE_TICK, 1'b0);
    endtask

    // largest thresholds and failure limit: no timeout fires, the run keeps rising
    task automatic test_large_thresholds();
        drain_and_settle();
        write_all(16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF);
        send_event(MODE_FRAME, 1'b1);
        repeat (20) send_event(MODE_TICK, 1'($urandom));
        repeat (20) send_event(MODE_FRAME, 1'b0);
        send_event(MODE_FRAME, 1'b1);
        send_event(MODE_TICK, 1'b0);
    endtask

    // random phases of tick runs, frame bursts and resets under random settings
    task automatic test_random_traffic();
        int          sent;
        int          target;
        int          kind;
        int          len;
        logic [15:0] sig;
        logic [15:0] pwr;
        logic [15:0] aut;
        logic [7:0]  lim;
        for (int p = 0; p < 6; p++) begin
            drain_and_settle();
            gap_level   = (p == 0) ? 0 : $urandom_range(0, 2);
            stall_level = (p == 0) ? 0 : $urandom_range(0, 2);
            sig = 16'($urandom_range(1, 20));
            pwr = 16'($urandom_range(1, 40));
            aut = 16'($urandom_range(1, 30));
            lim = 8'($urandom_range(1, 8));
            target = 100;
            if (p == 3)
                sig = 16'hFFFF;
            if (p == 5) begin
                lim    = 8'd255;
                target = 250;
            end
            write_all(sig, pwr, {8'($urandom), lim}, aut);
            sent = 0;
            while (sent < target) begin
                kind = $urandom_range(0, 99);
                if (kind < 45) begin
                    len = $urandom_range(1, int'(pwr) + int'(aut) + 4);
                    repeat (len) send_event(MODE_TICK, 1'($urandom));
                    sent += len;
                end else if (kind < 60) begin
                    len = $urandom_range(1, int'(lim) + 15);
                    repeat (len) send_event(MODE_FRAME, 1'b0);
                    sent += len;
                end else if (kind < 80) begin
                    send_event(MODE_FRAME, 1'b1);
                    sent++;
                end else if (kind < 90) begin
                    send_event(MODE_MANUAL_RESET, 1'($urandom));
                    sent++;
                end else if (kind < 95) begin
                    send_event(MODE_UNUSED, 1'($urandom));
                end else begin
                    send_event(MODE_FRAME, 1'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else begin
            stall_left   = pick_gap(stall_level);
            out_ch.ready = (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // compare each accepted status with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_status.link_state      = t_link'(out_ch.link_state);
            got_status.data_valid      = out_ch.data_valid;
            got_status.power_lost      = out_ch.power_lost;
            got_status.restart_request = out_ch.restart_request;
            got_status.fail_count      = out_ch.fail_count;
            if (status_q.size() == 0) begin
                report("status with no transaction pending");
            end else begin
                want_status = status_q.pop_front();
                if (got_status.link_state !== want_status.link_state)
                    report($sformatf("link_state %0d, want %0d",
                                     got_status.link_state, want_status.link_state));
                if (got_status.data_valid !== want_status.data_valid)
                    report($sformatf("data_valid %0b, want %0b",
                                     got_status.data_valid, want_status.data_valid));
                if (got_status.power_lost !== want_status.power_lost)
                    report($sformatf("power_lost %0b, want %0b",
                                     got_status.power_lost, want_status.power_lost));
                if (got_status.restart_request !== want_status.restart_request)
                    report($sformatf("restart_request %0b, want %0b",
                                     got_status.restart_request, want_status.restart_request));
                if (got_status.fail_count !== want_status.fail_count)
                    report($sformatf("fail_count %0d, want %0d",
                                     got_status.fail_count, want_status.fail_count));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[serial_link_health_monitor_top] ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_TICK;
        in_ch.crc_good = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_SIGNAL_LOST;
        cfg_ch.data    = '0;
        out_ch.ready   = 1'b0;
        error_count    = 0;
        gap_level      = 1;
        stall_level    = 1;
        stall_left     = 0;
        quiet_cycles   = 0;

        link_cfg.sig_lost_thr  = SIGNAL_LOST_RST;
        link_cfg.pwr_lost_thr  = POWER_LOST_RST;
        link_cfg.fail_limit    = FAIL_LIMIT_RST;
        link_cfg.auto_reset_ms = AUTO_RESET_RST;
        link_code        = LINK_RECONNECTING;
        silence_ms       = '0;
        since_restart_ms = '0;
        fail_run         = '0;
        last_good        = 1'b0;
        valid_flag       = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_threshold_extremes();
        test_large_thresholds();
        test_random_traffic();
        drain_and_settle();

        if (error_count == 0)
            $display("[serial_link_health_monitor_top] OK");
        else
            $display("[serial_link_health_monitor_top] ERROR");
        $finish;
    end

endmodule
